>>> src/pcwm_pkg.sv
// Package for the packed convolution window MAC unit.
// Holds shared types, lane constants, the item-function codes and the configuration register indexes.
// No dependencies.
package pcwm_pkg;

    localparam int LANES     = 4;
    localparam int VAL_W     = 16;
    localparam int SUM_W     = 32;
    localparam int ACC_W     = 48;
    localparam int ROW_AW    = 12;
    localparam int ROW_W     = LANES * VAL_W;
    localparam int PROD_W    = 2 * VAL_W;

    // Item function codes.
    localparam logic FUNC_WLOAD  = 1'b0;
    localparam logic FUNC_SOURCE = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_KW = 2'd0;
    localparam logic [1:0] REG_KH = 2'd1;
    localparam logic [1:0] REG_DG = 2'd2;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic signed [ACC_W-1:0] acc_t;

    // Classified tap command passed from the front to the back.
    typedef struct packed {
        val_t [LANES-1:0] src;
        logic             last;
    } tap_cmd_t;

endpackage

>>> src/pcwm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module pcwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/pcwm_front.sv
// Front end: accepts items, writes weight rows, counts taps and issues the
// four weight-row reads of each tap. Depends on pcwm_pkg and pcwm_ram.
module pcwm_front #(
    parameter int MAX_TAPS = 1024
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic                    func,
    input  logic [11:0]             weight_row,
    input  pcwm_pkg::val_t          val0,
    input  pcwm_pkg::val_t          val1,
    input  pcwm_pkg::val_t          val2,
    input  pcwm_pkg::val_t          val3,
    input  logic [2:0]              kw,
    input  logic [2:0]              kh,
    input  logic [4:0]              dg,
    input  logic                    q_full,
    output logic                    issue,
    output pcwm_pkg::tap_cmd_t      cmd,
    output logic [pcwm_pkg::ROW_W-1:0] row0,
    output logic [pcwm_pkg::ROW_W-1:0] row1,
    output logic [pcwm_pkg::ROW_W-1:0] row2,
    output logic [pcwm_pkg::ROW_W-1:0] row3
);

    localparam int TAP_W   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int TOT_W   = 13;
    localparam int BANK_AW = pcwm_pkg::ROW_AW - 2;

    logic [TAP_W-1:0] tap_reg;
    logic [TAP_W-1:0] tap_next;
    logic             accept;
    logic             src_acc;
    logic [TOT_W-1:0] total;
    logic [2:0]       kw1;
    logic [2:0]       kh1;
    logic [4:0]       dg1;
    logic [TOT_W-1:0] raw;
    logic             last;
    logic [pcwm_pkg::ROW_W-1:0] wrow;
    logic [pcwm_pkg::ROW_W-1:0] rd [pcwm_pkg::LANES];
    logic [BANK_AW-1:0] tap_addr;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;
    assign src_acc  = accept && (func == pcwm_pkg::FUNC_SOURCE);

    // Taps per window, registers of zero act as one, capped at MAX_TAPS.
    assign kw1 = (kw == 3'd0) ? 3'd1 : kw;
    assign kh1 = (kh == 3'd0) ? 3'd1 : kh;
    assign dg1 = (dg == 5'd0) ? 5'd1 : dg;
    assign raw = TOT_W'(kw1) * TOT_W'(kh1) * TOT_W'(dg1);
    assign total = (raw > TOT_W'(MAX_TAPS)) ? TOT_W'(MAX_TAPS) : raw;
    assign last = (TOT_W'(tap_reg) + TOT_W'(1)) >= total;

    assign tap_next = last ? '0 : tap_reg + TAP_W'(1);

    // Tap counter advances on each source transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg <= '0;
        end
        else if (src_acc)
        begin
            tap_reg <= tap_next;
        end
    end

    // Weight row packing; the tap address wraps with the row address space.
    assign wrow     = {val3, val2, val1, val0};
    assign tap_addr = BANK_AW'(tap_reg);

    // One bank per input channel: row r lives in bank r mod 4, so the four
    // rows of a tap are read together from four banks.
    for (genvar c = 0; c < pcwm_pkg::LANES; c++)
    begin : g_bank
        pcwm_ram #(.WIDTH(pcwm_pkg::ROW_W), .DEPTH(1 << BANK_AW)) u_ram (
            .clk   (clk),
            .we    (accept && (func == pcwm_pkg::FUNC_WLOAD)
                    && (weight_row[1:0] == 2'(c))),
            .waddr (weight_row[pcwm_pkg::ROW_AW-1:2]),
            .wdata (wrow),
            .re    (src_acc),
            .raddr (tap_addr),
            .rdata (rd[c])
        );
    end

    assign row0 = rd[0];
    assign row1 = rd[1];
    assign row2 = rd[2];
    assign row3 = rd[3];

    // Command travels alongside the registered read.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue <= 1'b0;
        end
        else
        begin
            issue <= src_acc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (src_acc)
        begin
            cmd.src  <= {val3, val2, val1, val0};
            cmd.last <= last;
        end
    end

endmodule

>>> src/pcwm_back.sv
// Back end: tap queue, sixteen multipliers, accumulators and the output
// register with saturation. Depends on pcwm_pkg.
module pcwm_back (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       issue,
    input  pcwm_pkg::tap_cmd_t         cmd,
    input  logic [pcwm_pkg::ROW_W-1:0] row0,
    input  logic [pcwm_pkg::ROW_W-1:0] row1,
    input  logic [pcwm_pkg::ROW_W-1:0] row2,
    input  logic [pcwm_pkg::ROW_W-1:0] row3,
    output logic                       q_full,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [31:0]         sum0,
    output logic signed [31:0]         sum1,
    output logic signed [31:0]         sum2,
    output logic signed [31:0]         sum3
);

    localparam int QD = 4;
    localparam int PW = pcwm_pkg::PROD_W;
    typedef struct packed {
        pcwm_pkg::tap_cmd_t               cmd;
        logic [pcwm_pkg::LANES*pcwm_pkg::ROW_W-1:0] rows;
    } qent_t;

    qent_t      q_reg [QD];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;
    logic       pop;
    qent_t      head;

    logic                        p_valid_reg;
    logic                        p_last_reg;
    logic signed [PW+1:0]        p_reg [pcwm_pkg::LANES];
    pcwm_pkg::acc_t              acc_reg [pcwm_pkg::LANES];
    pcwm_pkg::acc_t              acc_sum [pcwm_pkg::LANES];
    logic signed [31:0]          sat [pcwm_pkg::LANES];
    logic                        out_busy;
    logic                        fin;

    // The queue absorbs the in-flight read plus the product stage.
    assign q_full = cnt_reg >= 3'd2;
    assign head   = q_reg[rp_reg];
    assign out_busy = out_valid && out_stall;
    // A finishing tap must not collide with a held result.
    assign pop = (cnt_reg != 3'd0) && !(p_valid_reg && p_last_reg && out_busy);
    assign cnt_next = cnt_reg + 3'(issue) - 3'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (issue)
            begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            q_reg[wp_reg] <= '{cmd: cmd, rows: {row3, row2, row1, row0}};
        end
    end

    // Product stage: per output lane, the four products summed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            p_last_reg  <= 1'b0;
        end
        else if (!(p_valid_reg && p_last_reg && out_busy))
        begin
            p_valid_reg <= pop;
            p_last_reg  <= pop && head.cmd.last;
        end
    end

    for (genvar o = 0; o < pcwm_pkg::LANES; o++)
    begin : g_mac
        logic signed [PW-1:0] pr [pcwm_pkg::LANES];
        for (genvar c = 0; c < pcwm_pkg::LANES; c++)
        begin : g_mul
            assign pr[c] = head.cmd.src[c] *
                pcwm_pkg::val_t'(head.rows[c*pcwm_pkg::ROW_W + o*16 +: 16]);
        end
        always_ff @(posedge clk)
        begin
            if (pop)
            begin
                p_reg[o] <= (PW+2)'(pr[0]) + (PW+2)'(pr[1])
                          + (PW+2)'(pr[2]) + (PW+2)'(pr[3]);
            end
        end
        assign acc_sum[o] = acc_reg[o] + pcwm_pkg::ACC_W'(p_reg[o]);
        assign sat[o] = (acc_sum[o] > 48'sh0000_7FFF_FFFF) ? 32'sh7FFF_FFFF :
                        (acc_sum[o] < -48'sh0000_8000_0000) ? -32'sh8000_0000 :
                        acc_sum[o][31:0];
    end

    assign fin = p_valid_reg && p_last_reg && !out_busy;

    // Accumulate and hand off finished windows to the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int o = 0; o < pcwm_pkg::LANES; o++)
            begin
                acc_reg[o] <= '0;
            end
            out_valid <= 1'b0;
        end
        else
        begin
            if (p_valid_reg && !(p_last_reg && out_busy))
            begin
                for (int o = 0; o < pcwm_pkg::LANES; o++)
                begin
                    acc_reg[o] <= p_last_reg ? '0 : acc_sum[o];
                end
            end
            if (fin)
            begin
                out_valid <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            sum0 <= sat[0];
            sum1 <= sat[1];
            sum2 <= sat[2];
            sum3 <= sat[3];
        end
    end

endmodule

>>> src/packed_conv_window_mac_unit.sv
// Top level of the packed convolution window MAC unit.
// Depends on pcwm_pkg, pcwm_front, pcwm_back and pcwm_ram.
//
// Usage: weight rows are loaded with func 0 items, then source quads stream
// in with func 1, one per tap in depth group, kernel row, kernel column order.
// Both channels use valid and stall; a transfer happens when valid is high
// and stall is low. Configuration is written over the APB-style port at
// byte addresses 0 (kernel width), 4 (kernel height) and 8 (depth groups).
// Throughput is one item per cycle while the input is not stalled: each
// tap reads its four weight rows together from four RAM banks and feeds
// sixteen parallel multipliers. The result path is registered in order:
// the weight read at the transfer edge, then the queue write, the product
// sum, and the accumulate into the output register. Reset clears the tap
// counter, accumulators and control state; weight memory contents stay
// undefined until written. When the receiver stalls, the result holds,
// the back end stops, and once two taps wait in the four-entry queue the
// input stall rises.
module packed_conv_window_mac_unit #(
    parameter int MAX_TAPS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [11:0]        weight_row,
    input  logic signed [15:0] val0,
    input  logic signed [15:0] val1,
    input  logic signed [15:0] val2,
    input  logic signed [15:0] val3,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] sum0,
    output logic signed [31:0] sum1,
    output logic signed [31:0] sum2,
    output logic signed [31:0] sum3,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [2:0] kw_reg;
    logic [2:0] kh_reg;
    logic [4:0] dg_reg;
    logic       q_full;
    logic       issue;
    pcwm_pkg::tap_cmd_t cmd;
    logic [pcwm_pkg::ROW_W-1:0] row0;
    logic [pcwm_pkg::ROW_W-1:0] row1;
    logic [pcwm_pkg::ROW_W-1:0] row2;
    logic [pcwm_pkg::ROW_W-1:0] row3;

    assign pready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kw_reg <= 3'd3;
            kh_reg <= 3'd3;
            dg_reg <= 5'd1;
        end
        else if (psel && penable && pwrite && (paddr[1:0] == 2'b00))
        begin
            unique case (paddr[3:2])
                pcwm_pkg::REG_KW: kw_reg <= pwdata[2:0];
                pcwm_pkg::REG_KH: kh_reg <= pwdata[2:0];
                pcwm_pkg::REG_DG: dg_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    // Configuration readback.
    always_comb
    begin
        unique case (paddr[3:2])
            pcwm_pkg::REG_KW: prdata = {29'd0, kw_reg};
            pcwm_pkg::REG_KH: prdata = {29'd0, kh_reg};
            pcwm_pkg::REG_DG: prdata = {27'd0, dg_reg};
            default:          prdata = '0;
        endcase
    end

    pcwm_front #(.MAX_TAPS(MAX_TAPS)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .weight_row (weight_row),
        .val0       (val0),
        .val1       (val1),
        .val2       (val2),
        .val3       (val3),
        .kw         (kw_reg),
        .kh         (kh_reg),
        .dg         (dg_reg),
        .q_full     (q_full),
        .issue      (issue),
        .cmd        (cmd),
        .row0       (row0),
        .row1       (row1),
        .row2       (row2),
        .row3       (row3)
    );

    pcwm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .issue     (issue),
        .cmd       (cmd),
        .row0      (row0),
        .row1      (row1),
        .row2      (row2),
        .row3      (row3),
        .q_full    (q_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sum0      (sum0),
        .sum1      (sum1),
        .sum2      (sum2),
        .sum3      (sum3)
    );

endmodule

>>> src/pcwm_checker.sv
// Port-level checker for the packed convolution window MAC unit, bound to
// the top level. Depends on packed_conv_window_mac_unit ports only.
module pcwm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] sum0,
    input logic               pready
);

    // A held result keeps its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sum0))
        else $error("result changed while stalled");

    // The configuration port never waits.
    a_pready: assert property (@(posedge clk) pready)
        else $error("pready low");

    // Input stall only rises after a held result has blocked the back end.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall with no cause");

endmodule

bind packed_conv_window_mac_unit pcwm_checker u_pcwm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum0      (sum0),
    .pready    (pready)
);

>>> test/testbench.sv
// Self-checking testbench for packed_conv_window_mac_unit.
// Depends on pcwm_pkg and the unit's RTL; it predicts every window sum
// itself and checks each output transfer against it.
module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 10;
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic signed [31:0] s [4];
    } window_sums_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               func = pcwm_pkg::FUNC_WLOAD;
    logic [11:0]        weight_row = '0;
    logic signed [15:0] val0 = '0;
    logic signed [15:0] val1 = '0;
    logic signed [15:0] val2 = '0;
    logic signed [15:0] val3 = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] sum0;
    logic signed [31:0] sum1;
    logic signed [31:0] sum2;
    logic signed [31:0] sum3;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [3:0]         paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    // Shadow copy of the unit's state and registers.
    logic [63:0]        weight_mem [4096];
    bit                 row_loaded [4096];
    logic signed [47:0] acc_shadow [4];
    int unsigned        taps_done;
    int unsigned        kw_reg;
    int unsigned        kh_reg;
    int unsigned        dg_reg;

    window_sums_t       pending_sums [$];
    int                 errors = 0;
    int                 idle_mode = 0;
    int                 hold_req = 0;
    int                 hold_seen = 0;
    int                 hold_cnt = 0;
    int                 quiet_cycles = 0;
    bit                 cfg_fire = 1'b0;

    packed_conv_window_mac_unit uut (.*);

    always #2 clk = ~clk;

    function automatic int send_pct();
        return (idle_mode == 1) ? 57 : (idle_mode == 3) ? 9 : 0;
    endfunction

    function automatic int recv_pct();
        return (idle_mode == 2) ? 57 : (idle_mode == 3) ? 9 : 0;
    endfunction

    // Receiver: random stalls by phase, plus one long hold when requested.
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt = hold_cnt - 1;
            out_stall <= 1'b1;
        end
        else if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_cnt = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < recv_pct());
        end
    end

    // Output checker and watchdog; inputs settle by the falling edge.
    always @(negedge clk)
    begin
        window_sums_t want;
        logic signed [31:0] got [4];
        bit fired;
        got = '{sum0, sum1, sum2, sum3};
        fired = cfg_fire || (in_valid && !in_stall);
        if (rst_n && out_valid && !out_stall)
        begin
            fired = 1'b1;
            if (pending_sums.size() == 0)
            begin
                $display("%0t: unexpected result transfer %h %h %h %h",
                         $time, sum0, sum1, sum2, sum3);
                errors++;
            end
            else
            begin
                want = pending_sums.pop_front();
                for (int o = 0; o < 4; o++)
                begin
                    if (got[o] !== want.s[o])
                    begin
                        $display("%0t: sum%0d expected %h actual %h",
                                 $time, o, want.s[o], got[o]);
                        errors++;
                    end
                end
            end
        end
        quiet_cycles = fired ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("packed_conv_window_mac_unit verification failed");
            $finish;
        end
    end

    function automatic int unsigned at_least_one(int unsigned v);
        return (v == 0) ? 1 : v;
    endfunction

    function automatic logic signed [31:0] clamp32(logic signed [47:0] v);
        if (v > 48'sh0000_7FFF_FFFF)
            return 32'sh7FFF_FFFF;
        if (v < -48'sh0000_8000_0000)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Advance the shadow state by one accepted item.
    task automatic window_predict(logic f, logic [11:0] row, logic [63:0] lanes);
        int unsigned total;
        logic [11:0] addr;
        logic signed [15:0] src;
        logic signed [15:0] wt;
        window_sums_t sums;
        if (f == pcwm_pkg::FUNC_WLOAD)
        begin
            weight_mem[row] = lanes;
            row_loaded[row] = 1'b1;
        end
        else
        begin
            for (int c = 0; c < 4; c++)
            begin
                src = lanes[16*c +: 16];
                addr = 12'(taps_done * 4 + c);
                if (!row_loaded[addr])
                begin
                    $display("%0t: stimulus read an unloaded weight row %0d", $time, addr);
                    errors++;
                end
                for (int o = 0; o < 4; o++)
                begin
                    wt = weight_mem[addr][16*o +: 16];
                    acc_shadow[o] = acc_shadow[o] + 48'(src) * 48'(wt);
                end
            end
            total = at_least_one(kw_reg) * at_least_one(kh_reg) * at_least_one(dg_reg);
            if (total > 1024)
                total = 1024;
            if (taps_done + 1 >= total)
            begin
                for (int o = 0; o < 4; o++)
                begin
                    sums.s[o] = clamp32(acc_shadow[o]);
                    acc_shadow[o] = '0;
                end
                pending_sums.push_back(sums);
                taps_done = 0;
            end
            else
            begin
                taps_done++;
            end
        end
    endtask

    // Offer one item and return at the edge where it transfers.
    task automatic send_item(logic f, logic [11:0] row, logic [63:0] lanes);
        bit taken;
        while ($urandom_range(99) < send_pct())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        weight_row <= row;
        val0 <= lanes[15:0];
        val1 <= lanes[31:16];
        val2 <= lanes[47:32];
        val3 <= lanes[63:48];
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        window_predict(f, row, lanes);
    endtask

    function automatic logic [63:0] rand_lanes();
        return {$urandom(), $urandom()};
    endfunction

    task automatic send_source(logic [63:0] lanes);
        send_item(pcwm_pkg::FUNC_SOURCE, 12'($urandom()), lanes);
    endtask

    // Stop offering and let every pending result drain.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle.
    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        cfg_fire = 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_fire = 1'b0;
        if (idx == pcwm_pkg::REG_KW)
            kw_reg = {29'd0, value[2:0]};
        else if (idx == pcwm_pkg::REG_KH)
            kh_reg = {29'd0, value[2:0]};
        else if (idx == pcwm_pkg::REG_DG)
            dg_reg = {27'd0, value[4:0]};
    endtask

    task automatic set_window(int unsigned kw, int unsigned kh, int unsigned dg);
        drain();
        reg_write(pcwm_pkg::REG_KW, {8'($urandom_range(255)), 21'h0, 3'(kw)});
        reg_write(pcwm_pkg::REG_KH, 32'(kh));
        reg_write(pcwm_pkg::REG_DG, 32'(dg));
    endtask

    task automatic load_rows(int unsigned count);
        for (int unsigned r = 0; r < count; r++)
            send_item(pcwm_pkg::FUNC_WLOAD, 12'(r), rand_lanes());
    endtask

    // Default 3x3x1 window after reset.
    task automatic test_reset_window();
        load_rows(128);
        for (int i = 0; i < 9; i++)
            send_source(rand_lanes());
    endtask

    // Extreme weights and sources drive both saturation limits.
    task automatic test_saturation();
        set_window(1, 1, 1);
        for (int r = 0; r < 4; r++)
            send_item(pcwm_pkg::FUNC_WLOAD, 12'(r), {4{16'h8000}});
        send_source({4{16'h8000}});
        send_source({4{16'h7FFF}});
        send_source('0);
        for (int r = 0; r < 4; r++)
            send_item(pcwm_pkg::FUNC_WLOAD, 12'(r), {4{16'h7FFF}});
        send_source({4{16'h7FFF}});
        send_source({4{16'h8000}});
        send_item(pcwm_pkg::FUNC_WLOAD, 12'hFFF, {4{16'hFFFF}});
        load_rows(4);
    endtask

    // Registers of zero act as one tap.
    task automatic test_zero_registers();
        set_window(0, 0, 0);
        send_source(rand_lanes());
        send_source(rand_lanes());
        set_window(7, 0, 31);
        repeat (7) send_source(rand_lanes());
    endtask

    // Shrinking the window below the current tap ends it on the next tap.
    task automatic test_shrink_mid_window();
        set_window(3, 3, 1);
        repeat (5) send_source(rand_lanes());
        set_window(1, 2, 1);
        repeat (3) send_source(rand_lanes());
    endtask

    // Full 7 x 7 kernel over two depth groups: 98 taps over 392 weight rows.
    task automatic test_largest_window();
        set_window(7, 7, 2);
        load_rows(392);
        repeat (98) send_source(rand_lanes());
    endtask

    // Receiver holds off while the sender streams, so the input stalls.
    task automatic test_back_pressure();
        set_window(1, 2, 1);
        idle_mode = 0;
        hold_req++;
        repeat (40) send_source(rand_lanes());
    endtask

    // Random phases under every idling pattern.
    task automatic test_random_traffic();
        int unsigned kw;
        int unsigned kh;
        int unsigned dg;
        for (int m = 0; m < 4; m++)
        begin
            for (int p = 0; p < 4; p++)
            begin
                do
                begin
                    kw = $urandom_range(7);
                    kh = $urandom_range(7);
                    dg = $urandom_range(31);
                end
                while (at_least_one(kw) * at_least_one(kh) * at_least_one(dg) > 32);
                idle_mode = 0;
                set_window(kw, kh, dg);
                idle_mode = m;
                for (int i = 0; i < 55; i++)
                begin
                    if ($urandom_range(99) < 20)
                        send_item(pcwm_pkg::FUNC_WLOAD, 12'($urandom()), rand_lanes());
                    else
                        send_source(rand_lanes());
                end
            end
        end
        idle_mode = 0;
    endtask

    initial
    begin
        for (int i = 0; i < 4; i++)
            acc_shadow[i] = '0;
        taps_done = 0;
        kw_reg = 3;
        kh_reg = 3;
        dg_reg = 1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_window();
        test_saturation();
        test_zero_registers();
        test_shrink_mid_window();
        test_largest_window();
        test_back_pressure();
        test_random_traffic();
        drain();
        if (errors == 0)
            $display("packed_conv_window_mac_unit verification clean");
        else
            $display("packed_conv_window_mac_unit verification failed");
        $finish;
    end

endmodule
